>>> design/mhu_pkg.sv
package mhu_pkg;

   localparam int SITES_DEF = 256;
   localparam int HEIGHT_LIMIT_DEF = 512;
   localparam int HW = 10;
   localparam int SOSW = 14;
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;

   typedef enum logic [1:0] {
      OP_MOVE = 2'd0,
      OP_LOAD = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   localparam logic [0:0] CSR_BETA = 1'b0;
   localparam logic [0:0] CSR_FIELD = 1'b1;

   typedef struct packed {
      op_type      op;
      logic [7:0]  site;
      logic        direction;
      logic [31:0] random_fraction;
      logic [9:0]  load_value;
   } item_type;

   function automatic logic [63:0] mulhi(input logic [63:0] u, input logic [63:0] v);
      logic [127:0] p;
      begin
         p = u * v;
         mulhi = p[127:64];
      end
   endfunction

   function automatic logic [63:0] rom_base();
      logic [63:0] a;
      logic [63:0] t;
      logic [63:0] r;
      begin
         a = LN2_Q64 >> 8;
         t = a;
         r = 64'd0 - a;
         for (int k = 2; k <= 10; k++) begin
            t = mulhi(t, a) / 64'(k);
            if (k % 2 == 1) r = r - t;
            else r = r + t;
         end
         rom_base = r;
      end
   endfunction

   typedef logic [32:0] rom_arr_type [256];

   function automatic rom_arr_type build_rom();
      rom_arr_type rv;
      logic [63:0] p;
      logic [64:0] s;
      begin
         rv[0] = 33'h1_0000_0000;
         p = rom_base();
         for (int f = 1; f < 256; f++) begin
            s = {1'b0, p} + 65'h8000_0000;
            rv[f] = s[64:32];
            p = mulhi(p, rom_base());
         end
         build_rom = rv;
      end
   endfunction

   localparam rom_arr_type EXP_ROM = build_rom();

endpackage

>>> design/mhu_front.sv
module mhu_front #(
   parameter int SITES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mhu_pkg::item_type  req_item,
   output logic               q_valid,
   input  logic               q_pop,
   output mhu_pkg::item_type  q_item
);
   import mhu_pkg::*;
   // site mod SITES by reciprocal multiply, exact for 8-bit sites
   localparam int RK = 24;
   localparam logic [22:0] RECIP = 23'((2**RK + SITES - 1) / SITES);

   item_type   buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic       push;
   item_type   cls;
   logic [30:0] prod;
   logic [6:0]  quot;

   always_comb begin
      prod = 31'(req_item.site) * 31'(RECIP);
      quot = prod[30:24];
      cls = req_item;
      cls.site = req_item.site - 8'(32'(quot) * SITES);
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = buf_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ (q_pop && q_valid);
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
      if (push) buf_ff[wp_ff] <= cls;
   end
endmodule

>>> design/mhu_back.sv
module mhu_back #(
   parameter int SITES = 256,
   parameter int HEIGHT_LIMIT = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  mhu_pkg::item_type q_item,
   input  logic [15:0]       beta,
   input  logic signed [15:0] field,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_accepted,
   output logic signed [9:0] rsp_height,
   output logic signed [13:0] rsp_sos_change
);
   import mhu_pkg::*;
   localparam int AW = (SITES > 1) ? $clog2(SITES) : 1;

   typedef enum logic [9:0] {
      S_CLR   = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_RD_C  = 10'b0000000100,
      S_RD_L  = 10'b0000001000,
      S_RD_R  = 10'b0000010000,
      S_ENER  = 10'b0000100000,
      S_MUL   = 10'b0001000000,
      S_LOG   = 10'b0010000000,
      S_DEC   = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } st_type;

   st_type st_ff, st_in;
   logic [HW-1:0] mem [SITES];
   logic [AW-1:0] clr_ff, clr_in;
   logic signed [HW-1:0] rd_ff;
   logic [AW-1:0] ra;
   logic signed [HW-1:0] h_ff, hl_ff, hr_ff;
   logic signed [SOSW-1:0] sos_ff;
   logic signed [31:0] e_ff;
   logic ok_ff;
   logic [48:0] x_ff;
   logic [33:0] tq_ff;
   logic acc_c;
   logic wr_c;
   logic [AW-1:0] xa;

   assign xa = AW'(q_item.site);

   always_comb begin
      ra = xa;
      case (st_ff)
         S_RD_C: ra = (xa == AW'(0)) ? AW'(SITES - 1) : xa - AW'(1);
         S_RD_L: ra = (xa == AW'(SITES - 1)) ? AW'(0) : xa + AW'(1);
         default: ra = xa;
      endcase
   end

   logic signed [HW:0] hn;
   logic signed [HW+2:0] dsum;
   logic signed [SOSW-1:0] sosv;
   logic signed [1:0] sv;
   logic [HW-1:0] an, ao;
   logic okv;
   always_comb begin
      hn = {h_ff[HW-1], h_ff} + (q_item.direction ? 11'sd1 : -11'sd1);
      dsum = 13'(2 * h_ff) - 13'(hl_ff) - 13'(hr_ff);
      sosv = q_item.direction ? 14'(2 * dsum + 2) : 14'(-2 * dsum + 2);
      an = hn[HW] ? HW'(-hn) : HW'(hn);
      ao = h_ff[HW-1] ? HW'(-h_ff) : HW'(h_ff);
      sv = (an > ao) ? 2'sd1 : (an < ao) ? -2'sd1 : 2'sd0;
      okv = (hn > -HEIGHT_LIMIT) && (hn < HEIGHT_LIMIT) && (hn >= -512) && (hn <= 511);
   end

   // beta*E then *log2e, registered between multiplies
   logic [48:0] xs;
   logic [65:0] tp;
   assign xs = 49'(beta) * 49'(e_ff[31:0] & {32{~e_ff[31]}});
   assign tp = 66'(x_ff) * 66'(LOG2E_Q16);

   logic [32:0] pr;
   always_comb begin
      pr = EXP_ROM[tq_ff[7:0]] >> tq_ff[12:8];
      if (!ok_ff) acc_c = 1'b0;
      else if (e_ff <= 0 || beta == 16'd0) acc_c = 1'b1;
      else if (tq_ff >= 34'd8192) acc_c = 1'b0;
      else acc_c = {1'b0, q_item.random_fraction} < pr;
   end

   assign wr_c = (st_ff == S_DEC) && (q_item.op == OP_LOAD || (q_item.op == OP_MOVE && acc_c));
   assign q_pop = (st_ff == S_DONE) && !rsp_stall;
   assign rsp_valid = (st_ff == S_DONE);

   always_comb begin
      st_in = st_ff;
      clr_in = clr_ff;
      case (st_ff)
         S_CLR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(SITES - 1)) st_in = S_IDLE;
         end
         S_IDLE: if (q_valid) st_in = S_RD_C;
         S_RD_C: st_in = S_RD_L;
         S_RD_L: st_in = S_RD_R;
         S_RD_R: st_in = S_ENER;
         S_ENER: st_in = S_MUL;
         S_MUL:  st_in = S_LOG;
         S_LOG:  st_in = S_DEC;
         S_DEC:  st_in = S_DONE;
         S_DONE: if (!rsp_stall) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLR;
         clr_ff <= '0;
      end else begin
         st_ff <= st_in;
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[ra];
      if (st_ff == S_CLR) mem[clr_ff] <= '0;
      else if (wr_c) mem[xa] <= (q_item.op == OP_LOAD) ? q_item.load_value : HW'(hn);
      case (st_ff)
         S_RD_C: h_ff <= rd_ff;
         S_RD_L: hl_ff <= rd_ff;
         S_RD_R: hr_ff <= rd_ff;
         S_ENER: begin
            sos_ff <= sosv;
            ok_ff <= okv;
            e_ff <= 32'(sosv) * 32'sd8192 + 32'(field) * 32'(sv);
         end
         default: ;
      endcase
      x_ff <= xs;
      tq_ff <= 34'(tp >> 33);
   end

   always_ff @(posedge clock) begin
      if (st_ff == S_DEC) begin
         rsp_accepted <= (q_item.op == OP_LOAD) || (q_item.op == OP_MOVE && acc_c);
         rsp_sos_change <= (q_item.op == OP_MOVE) ? sos_ff : '0;
         if (q_item.op == OP_LOAD) rsp_height <= q_item.load_value;
         else if (q_item.op == OP_MOVE && acc_c) rsp_height <= HW'(hn);
         else rsp_height <= h_ff;
      end
   end
endmodule

>>> design/metropolis_height_update.sv
// Metropolis height update on a ring of SITES heights.
// Input channel req_*: op (move, load, read), site, direction,
// random_fraction, load_value. Output channel rsp_*: accepted, height and
// sos_change, one result per item, in order.
// csr_*: write beta (index 0) or field (index 1) while idle.
// A two-entry item queue separates the front from the back end, so the
// input keeps taking items while a result waits on rsp_stall.
// The back end handles one item at a time and takes the next only after
// its result is taken; its steps are three reads on the single height
// memory port (center, left, right), two registered multiplies and the
// accept decision.
// Reset sets beta to 1805 and field to 0 and starts a clearing pass that
// writes every height to zero; items wait in the queue.
// While rsp_stall is high the result holds and the queue fills; req_stall
// rises when two items are queued.
module metropolis_height_update #(
   parameter int SITES = mhu_pkg::SITES_DEF,
   parameter int HEIGHT_LIMIT = mhu_pkg::HEIGHT_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_site,
   input  logic        req_direction,
   input  logic [31:0] req_random_fraction,
   input  logic signed [9:0] req_load_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic signed [9:0] rsp_height,
   output logic signed [13:0] rsp_sos_change,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import mhu_pkg::*;

   logic [15:0] beta_ff;
   logic signed [15:0] field_ff;
   item_type in_item, q_item;
   logic q_valid, q_pop;

   always_comb begin
      in_item.op = op_type'(req_op);
      in_item.site = req_site;
      in_item.direction = req_direction;
      in_item.random_fraction = req_random_fraction;
      in_item.load_value = req_load_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff <= 16'd1805;
         field_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BETA: beta_ff <= csr_data;
            CSR_FIELD: field_ff <= csr_data;
            default: ;
         endcase
      end
   end

   mhu_front #(.SITES(SITES)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_item(in_item),
      .q_valid, .q_pop, .q_item
   );

   mhu_back #(.SITES(SITES), .HEIGHT_LIMIT(HEIGHT_LIMIT)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_item,
      .beta(beta_ff), .field(field_ff),
      .rsp_valid, .rsp_stall, .rsp_accepted, .rsp_height, .rsp_sos_change
   );

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_height))
      else $error("result dropped");
   a_hold_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_accepted) && $stable(rsp_sos_change))
      else $error("stalled result changed");
endmodule
